[hdl/lpmt_pkg.sv]
// Shared types and codes for the lidar point merge table.
package lpmt_pkg;

    // result status codes
    localparam logic [2:0] ST_INSERTED    = 3'd0;
    localparam logic [2:0] ST_MERGED      = 3'd1;
    localparam logic [2:0] ST_ZERO        = 3'd2;
    localparam logic [2:0] ST_FULL        = 3'd3;
    localparam logic [2:0] ST_DRAINED     = 3'd4;
    localparam logic [2:0] ST_DRAIN_EMPTY = 3'd5;

    localparam logic [16:0] FULL_TURN = 17'd23040;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // classified command handed from front to back
    typedef struct packed {
        logic        drain;
        logic        zero;
        logic [15:0] servo;
        logic [14:0] angle;
        logic [23:0] newd;
    } t_cmd;

    // one table entry
    typedef struct packed {
        logic [15:0] servo;
        logic [14:0] angle;
        logic [23:0] meas;
    } t_entry;

    // one result item
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  entry_index;
        logic [23:0] dist_out;
        logic [14:0] scan_angle;
        logic [15:0] servo_out;
        logic        last;
    } t_result;

endpackage

[hdl/lpmt_front.sv]
// Front end: accepts samples, forms the wrapped lidar angle and classifies the item.
module lpmt_front
    import lpmt_pkg::*;
#(
    parameter int DIST_FRAC_BITS = 8
) (
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [15:0] i_servo_pos,
    input  logic [14:0] i_start_raw,
    input  logic [4:0]  i_comp_raw,
    input  logic [15:0] i_dist_raw,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_cmd        o_q_cmd
);

    logic signed [16:0] w_corr;
    logic signed [16:0] w_sum;
    logic [16:0]        w_wrap;

    always_comb begin
        w_corr = signed'({10'd0, i_comp_raw[3:0], 3'b000});
        if (i_comp_raw[4]) begin
            w_corr = -w_corr;
        end
        w_sum = signed'({2'b00, i_start_raw}) + w_corr;
        if (w_sum >= signed'(FULL_TURN)) begin
            w_wrap = unsigned'(w_sum) - FULL_TURN;
        end else if (w_sum < 0) begin
            w_wrap = unsigned'(w_sum) + FULL_TURN;
        end else begin
            w_wrap = unsigned'(w_sum);
        end
    end

    always_comb begin
        o_q_cmd.drain = i_kind;
        o_q_cmd.zero  = (i_dist_raw == 16'd0);
        o_q_cmd.servo = i_servo_pos;
        o_q_cmd.angle = w_wrap[14:0];
        o_q_cmd.newd  = {8'd0, i_dist_raw} << DIST_FRAC_BITS;
    end

    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full;

endmodule

[hdl/lpmt_queue.sv]
// Short command queue between the front end and the table engine.
module lpmt_queue
    import lpmt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_PTR_W:0]    r_fill;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    assign o_full  = (r_fill == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

[hdl/lpmt_back.sv]
// Table engine: sequential search, merge, append and drain over the entry memory.
module lpmt_back
    import lpmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_cmd    i_q_cmd,
    output logic    o_q_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN
    } t_state;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    t_state        r_state,     n_state;
    t_cmd          r_cmd,       n_cmd;
    logic [CW-1:0] r_count,     n_count;
    logic [CW-1:0] r_addr,      n_addr;
    logic          r_pend,      n_pend;
    logic [IW-1:0] r_pidx,      n_pidx;
    logic          r_out_valid, n_out_valid;
    t_result       r_out,       n_out;

    logic          w_rd_en;
    logic [IW-1:0] w_rd_addr;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    t_entry        w_wr_data;
    logic          w_out_free;
    logic          w_match;
    logic          w_consume;
    logic          w_is_last;
    logic [24:0]   w_sum;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_match    = r_pend && (r_rd_data.servo == r_cmd.servo)
                        && (r_rd_data.angle == r_cmd.angle);
    assign w_is_last  = ((CW'(r_pidx) + CW'(1)) == r_count);
    assign w_consume  = r_pend && w_out_free;
    assign w_sum      = {1'b0, r_rd_data.meas} + {1'b0, r_cmd.newd};

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_addr[IW-1:0];
        w_wr_en     = 1'b0;
        w_wr_addr   = r_pidx;
        w_wr_data   = '{servo: r_cmd.servo, angle: r_cmd.angle, meas: w_sum[24:1]};

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.drain && (r_count == '0)) begin
                        if (w_out_free) begin
                            o_q_pop     = 1'b1;
                            n_out_valid = 1'b1;
                            n_out       = '{status: ST_DRAIN_EMPTY, entry_index: 6'd0,
                                            dist_out: 24'd0, scan_angle: 15'd0,
                                            servo_out: 16'd0, last: 1'b1};
                        end
                    end else if (i_q_cmd.drain) begin
                        o_q_pop = 1'b1;
                        n_addr  = '0;
                        n_pend  = 1'b0;
                        n_state = S_DRAIN;
                    end else if (i_q_cmd.zero) begin
                        if (w_out_free) begin
                            o_q_pop     = 1'b1;
                            n_out_valid = 1'b1;
                            n_out       = '{status: ST_ZERO, entry_index: 6'd0,
                                            dist_out: 24'd0, scan_angle: i_q_cmd.angle,
                                            servo_out: i_q_cmd.servo, last: 1'b1};
                        end
                    end else begin
                        o_q_pop = 1'b1;
                        n_cmd   = i_q_cmd;
                        n_addr  = '0;
                        n_pend  = 1'b0;
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (w_match) begin
                    if (w_out_free) begin
                        w_wr_en     = 1'b1;
                        w_wr_addr   = r_pidx;
                        n_pend      = 1'b0;
                        n_out_valid = 1'b1;
                        n_out       = '{status: ST_MERGED, entry_index: 6'(r_pidx),
                                        dist_out: w_sum[24:1], scan_angle: r_cmd.angle,
                                        servo_out: r_cmd.servo, last: 1'b1};
                        n_state     = S_IDLE;
                    end
                end else if (r_addr < r_count) begin
                    w_rd_en = 1'b1;
                    n_pidx  = r_addr[IW-1:0];
                    n_pend  = 1'b1;
                    n_addr  = r_addr + CW'(1);
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_count >= CW'(TABLE_DEPTH)) begin
                        n_out = '{status: ST_FULL, entry_index: 6'd0,
                                  dist_out: r_cmd.newd, scan_angle: r_cmd.angle,
                                  servo_out: r_cmd.servo, last: 1'b1};
                    end else begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_count[IW-1:0];
                        w_wr_data = '{servo: r_cmd.servo, angle: r_cmd.angle,
                                      meas: r_cmd.newd};
                        n_count   = r_count + CW'(1);
                        n_out     = '{status: ST_INSERTED,
                                      entry_index: 6'(r_count[IW-1:0]),
                                      dist_out: r_cmd.newd, scan_angle: r_cmd.angle,
                                      servo_out: r_cmd.servo, last: 1'b1};
                    end
                end
            end
            S_DRAIN: begin
                if (w_consume) begin
                    n_pend      = 1'b0;
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_DRAINED, entry_index: 6'(r_pidx),
                                    dist_out: r_rd_data.meas,
                                    scan_angle: r_rd_data.angle,
                                    servo_out: r_rd_data.servo, last: w_is_last};
                    if (w_is_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end
                end
                if ((!r_pend || (w_consume && !w_is_last)) && (r_addr < r_count)) begin
                    w_rd_en = 1'b1;
                    n_pidx  = r_addr[IW-1:0];
                    n_pend  = 1'b1;
                    n_addr  = r_addr + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_cmd  <= n_cmd;
        r_pidx <= n_pidx;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_pend_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (CW'(r_pidx) < r_count))
        else $error("pending read beyond valid entries");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && w_consume && w_is_last) |=>
            (r_count == '0 && r_state == S_IDLE))
        else $error("table not cleared after last drained entry");

    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> !w_wr_en)
        else $error("table write during drain");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_q_pop)
        else $error("queue popped while engine busy");
`endif

endmodule

[hdl/lidar_point_merge_table.sv]
// Top level of the lidar point merge table.
//
// Input stream: one transaction per item. tuser is the kind (0 add sample,
// 1 drain). An add sample gives one result: inserted, merged, zero ignored
// or table full dropped. A drain gives one result per stored entry, in
// entry order with tlast on the final one, then empties the table; an
// empty drain gives a single drain-empty result.
// Output stream: status in tuser, tlast on the final result of an item.
// Samples pass a combinational front end (angle and classification) into
// a four-deep command queue, so input keeps flowing while the table engine
// or the receiver stalls, until the queue is full. The engine searches the
// N valid entries through one registered memory read port, one entry a
// cycle; a drain reads the entries the same way while the receiver keeps
// taking results. The output register holds a result until the receiver
// takes it; the engine stalls meanwhile once it has a further result to
// hand over. Reset empties the queue and the table at once; no clearing
// pass is needed.
module lidar_point_merge_table
    import lpmt_pkg::*;
#(
    parameter int TABLE_DEPTH    = 64,
    parameter int DIST_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // servo_pos[15:0], start_raw[30:16], comp_raw[35:31], dist_raw[51:36]
    input  logic [55:0] i_s_axis_tdata,
    // kind[0]
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // entry_index[5:0], dist_out[29:6], scan_angle[44:30], servo_out[60:45]
    output logic [63:0] o_m_axis_tdata,
    // status[2:0]
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    logic    w_q_full;
    logic    w_q_push;
    t_cmd    w_push_cmd;
    logic    w_q_pop;
    logic    w_q_valid;
    t_cmd    w_q_cmd;
    t_result w_out;

    lpmt_front #(
        .DIST_FRAC_BITS(DIST_FRAC_BITS)
    ) u_front (
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser[0]),
        .i_servo_pos (i_s_axis_tdata[15:0]),
        .i_start_raw (i_s_axis_tdata[30:16]),
        .i_comp_raw  (i_s_axis_tdata[35:31]),
        .i_dist_raw  (i_s_axis_tdata[51:36]),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_cmd     (w_push_cmd)
    );

    lpmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    lpmt_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (w_out)
    );

    assign o_m_axis_tdata = {3'd0, w_out.servo_out, w_out.scan_angle,
                             w_out.dist_out, w_out.entry_index};
    assign o_m_axis_tuser = w_out.status;
    assign o_m_axis_tlast = w_out.last;

endmodule
